// ----- src/mft_pkg.sv -----
// Package for the multi-turn motor feedback tracker.
// Field widths, register reset value and the per-slot state record.
// No dependencies; read by the interfaces, the RAM user and the top level.
`default_nettype none
package mft_pkg;

	localparam int SLOT_W    = 4;
	localparam int ANGLE_W   = 13;
	localparam int SPEED_W   = 16;
	localparam int CURRENT_W = 16;
	localparam int TEMP_W    = 8;
	localparam int SCALED_W  = 19;
	localparam int TURN_W    = 16;
	localparam int TOTAL_W   = 30;
	localparam int CNT_W     = 6;

	localparam int NUM_MOTORS_DEF      = 10;
	localparam int COUNTS_PER_TURN_DEF = 8192;

	localparam logic [CNT_W-1:0] CALIB_RESET = CNT_W'(50);
	localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

	// One slot's state as held in the RAM
	typedef struct packed {
		logic [CNT_W-1:0]   frame_cnt;
		logic [ANGLE_W-1:0] prev_angle;
		logic [ANGLE_W-1:0] zero_angle;
		logic [TURN_W-1:0]  turns;
	} slot_state_t;

	localparam int STATE_W = $bits(slot_state_t);

endpackage
`default_nettype wire

// ----- src/mft_if.sv -----
// Handshake channels of the tracker: feedback frames in, tracked results out.
// Depends on mft_pkg for the field widths.
`default_nettype none
interface mft_frame_if
	import mft_pkg::*;
	();
	logic                        valid;
	logic                        ready;
	logic [SLOT_W-1:0]           motor_slot;
	logic [ANGLE_W-1:0]          encoder_angle;
	logic signed [SPEED_W-1:0]   speed_word;
	logic [CURRENT_W-1:0]        current_word;
	logic [TEMP_W-1:0]           temperature_byte;

	modport source (output valid, motor_slot, encoder_angle, speed_word, current_word,
		temperature_byte, input ready);
	modport sink (input valid, motor_slot, encoder_angle, speed_word, current_word,
		temperature_byte, output ready);
endinterface

interface mft_result_if
	import mft_pkg::*;
	();
	logic                        valid;
	logic                        ready;
	logic [SLOT_W-1:0]           slot_out;
	logic                        calibrating;
	logic [ANGLE_W-1:0]          angle_out;
	logic signed [SPEED_W-1:0]   speed_out;
	logic [SCALED_W-1:0]         current_scaled;
	logic [TEMP_W-1:0]           temperature_out;
	logic signed [TURN_W-1:0]    turn_count;
	logic signed [TOTAL_W-1:0]   accum_angle;

	modport source (output valid, slot_out, calibrating, angle_out, speed_out,
		current_scaled, temperature_out, turn_count, accum_angle, input ready);
	modport sink (input valid, slot_out, calibrating, angle_out, speed_out,
		current_scaled, temperature_out, turn_count, accum_angle, output ready);
endinterface
`default_nettype wire

// ----- src/mft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none
module mft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/multiturn_motor_feedback_tracker.sv -----
// Top level of the multi-turn motor feedback tracker.
// Depends on mft_pkg, mft_frame_if / mft_result_if and mft_ram.
//
// Usage:
//   frame  : one decoded feedback frame per transfer (slot, angle, speed,
//            current code, temperature). ready/valid handshake.
//   result : exactly one tracked result per frame, in order.
//   cfg_we / cfg_wdata : write calib_frames (reset 50); write only while idle.
// Path: a frame transfer loads stage 1, which moves into the output register.
// Throughput: one frame per cycle, back to back, while result is taken; the
//   slot state RAM is read at the transfer and written back as stage 1 moves
//   on, with the written entry forwarded to a following frame of the same slot.
// Reset: per-slot valid bits clear at once, so every slot reads as all zero
//   and the block is ready straight after reset; no clearing pass.
// Stall: while result is held, one more frame is taken into the stage ahead
//   of the output register, then frame.ready drops until result moves.
// Frames whose slot is at or above NUM_MOTORS change no state and report
//   zero turns, zero total angle and no calibration.
`default_nettype none
module multiturn_motor_feedback_tracker
	import mft_pkg::*;
#(
	parameter int NUM_MOTORS      = NUM_MOTORS_DEF,
	parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	mft_frame_if.sink             frame,
	mft_result_if.source          result,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);

	localparam int ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int EXT_W  = ADDR_W + SLOT_W;
	localparam int DIFF_W = 18;
	localparam int PROD_W = 40;
	localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(COUNTS_PER_TURN / 2);
	localparam logic signed [PROD_W-1:0] CPT       = PROD_W'(COUNTS_PER_TURN);

	logic [CNT_W-1:0] calib_q;

	// stage 1
	logic                      valid_s1;
	logic                      in_range_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic [SLOT_W-1:0]         slot_s1;
	logic [ANGLE_W-1:0]        angle_s1;
	logic signed [SPEED_W-1:0] speed_s1;
	logic [CURRENT_W-1:0]      current_s1;
	logic [TEMP_W-1:0]         temp_s1;
	logic                      vld_s1;
	logic                      fwd_hit_s1;
	slot_state_t               fwd_data_s1;

	// output register
	logic                      out_valid_q;
	logic [SLOT_W-1:0]         slot_q;
	logic                      cal_q;
	logic [ANGLE_W-1:0]        angle_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic [SCALED_W-1:0]       scaled_q;
	logic [TEMP_W-1:0]         temp_q;
	logic signed [TURN_W-1:0]  turns_q;
	logic signed [TOTAL_W-1:0] total_q;

	logic [NUM_MOTORS-1:0]     entry_vld_q;

	logic                      out_free;
	logic                      adv_s1;
	logic                      accept;
	logic [EXT_W-1:0]          slot_ext;
	logic [ADDR_W-1:0]         addr_in;
	logic                      in_range_in;
	logic [STATE_W-1:0]        ram_rdata;
	logic                      ram_we;
	slot_state_t               cur_st;
	slot_state_t               new_st;
	logic                      cal_c;
	logic signed [DIFF_W-1:0]  diff_c;
	logic signed [PROD_W-1:0]  total_full;
	logic [SCALED_W-1:0]       scaled_c;

	assign out_free    = !out_valid_q || result.ready;
	assign adv_s1      = valid_s1 && out_free;
	assign frame.ready = !valid_s1 || out_free;
	assign accept      = frame.valid && frame.ready;

	assign slot_ext    = {{ADDR_W{1'b0}}, frame.motor_slot};
	assign addr_in     = slot_ext[ADDR_W-1:0];
	assign in_range_in = slot_ext < EXT_W'(NUM_MOTORS);

	assign ram_we = adv_s1 && in_range_s1;

	mft_ram #(
		.WIDTH (STATE_W),
		.DEPTH (NUM_MOTORS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (new_st),
		.re    (accept),
		.raddr (addr_in),
		.rdata (ram_rdata)
	);

	// Pick the state this frame sees: forwarded write, stored entry or reset value
	always_comb begin
		if (fwd_hit_s1) begin
			cur_st = fwd_data_s1;
		end else if (vld_s1) begin
			cur_st = slot_state_t'(ram_rdata);
		end else begin
			cur_st = '0;
		end
	end

	always_comb begin
		cal_c  = cur_st.frame_cnt <= calib_q;
		diff_c = $signed({{(DIFF_W-ANGLE_W){1'b0}}, angle_s1})
			- $signed({{(DIFF_W-ANGLE_W){1'b0}}, cur_st.prev_angle});
		new_st            = cur_st;
		new_st.prev_angle = angle_s1;
		if (cal_c) begin
			new_st.zero_angle = angle_s1;
		end else if (diff_c > HALF_TURN) begin
			new_st.turns = cur_st.turns - TURN_W'(1);
		end else if (diff_c < -HALF_TURN) begin
			new_st.turns = cur_st.turns + TURN_W'(1);
		end
		if (cur_st.frame_cnt != CNT_MAX) begin
			new_st.frame_cnt = cur_st.frame_cnt + CNT_W'(1);
		end
		total_full = $signed({{(PROD_W-TURN_W){new_st.turns[TURN_W-1]}}, new_st.turns}) * CPT
			+ $signed({{(PROD_W-ANGLE_W){1'b0}}, angle_s1})
			- $signed({{(PROD_W-ANGLE_W){1'b0}}, new_st.zero_angle});
		scaled_c = ({3'b000, current_s1} << 2) + {3'b000, current_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q     <= CALIB_RESET;
			valid_s1    <= 1'b0;
			fwd_hit_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			entry_vld_q <= '0;
		end else begin
			if (cfg_we) begin
				calib_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1   <= 1'b1;
				fwd_hit_s1 <= ram_we && (addr_s1 == addr_in);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (ram_we) begin
				entry_vld_q[addr_s1] <= 1'b1;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: capture at transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= in_range_in;
			addr_s1     <= addr_in;
			slot_s1     <= frame.motor_slot;
			angle_s1    <= frame.encoder_angle;
			speed_s1    <= frame.speed_word;
			current_s1  <= frame.current_word;
			temp_s1     <= frame.temperature_byte;
			vld_s1      <= in_range_in && entry_vld_q[addr_in];
			fwd_data_s1 <= new_st;
		end
		if (adv_s1) begin
			slot_q   <= slot_s1;
			angle_q  <= angle_s1;
			speed_q  <= speed_s1;
			scaled_q <= scaled_c;
			temp_q   <= temp_s1;
			if (in_range_s1) begin
				cal_q   <= cal_c;
				turns_q <= new_st.turns;
				total_q <= total_full[TOTAL_W-1:0];
			end else begin
				cal_q   <= 1'b0;
				turns_q <= '0;
				total_q <= '0;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.slot_out        = slot_q;
	assign result.calibrating     = cal_q;
	assign result.angle_out       = angle_q;
	assign result.speed_out       = speed_q;
	assign result.current_scaled  = scaled_q;
	assign result.temperature_out = temp_q;
	assign result.turn_count      = turns_q;
	assign result.accum_angle     = total_q;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the multi-turn motor feedback tracker.
// Depends on mft_pkg, mft_frame_if / mft_result_if and the tracker top level.
module tb;
	import mft_pkg::*;

	localparam int NUM_SLOTS   = NUM_MOTORS_DEF;
	localparam int TURN_COUNTS = COUNTS_PER_TURN_DEF;
	localparam int HALF_TURN   = TURN_COUNTS / 2;
	localparam int STALL_LIMIT = 1000;
	localparam int LONG_HOLD   = 300;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic [SLOT_W-1:0]         slot;
		logic [ANGLE_W-1:0]        angle;
		logic signed [SPEED_W-1:0] speed;
		logic [CURRENT_W-1:0]      current;
		logic [TEMP_W-1:0]         temp;
	} frame_t;

	typedef struct packed {
		logic [SLOT_W-1:0]         slot;
		logic                      cal;
		logic [ANGLE_W-1:0]        angle;
		logic signed [SPEED_W-1:0] speed;
		logic [SCALED_W-1:0]       current;
		logic [TEMP_W-1:0]         temp;
		logic signed [TURN_W-1:0]  turns;
		logic signed [TOTAL_W-1:0] total;
	} track_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	mft_frame_if  frame_ch ();
	mft_result_if result_ch ();

	multiturn_motor_feedback_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Tracker state as the block should hold it
	logic [CNT_W-1:0]         calib_setting = CALIB_RESET;
	logic [CNT_W-1:0]         frame_cnt_slot [NUM_SLOTS] = '{default: '0};
	logic [ANGLE_W-1:0]       prev_angle_slot [NUM_SLOTS] = '{default: '0};
	logic [ANGLE_W-1:0]       offset_slot [NUM_SLOTS] = '{default: '0};
	logic signed [TURN_W-1:0] turns_slot [NUM_SLOTS] = '{default: '0};

	logic [ANGLE_W-1:0] angle_track [NUM_SLOTS] = '{default: '0};

	track_result_t pending_results [$];
	int  mismatch_count = 0;
	bit  send_steady = 0;
	bit  recv_steady = 0;
	bit  offering = 0;
	int  hold_req = 0;
	int  hold_left = 0;
	int  recv_wait = 0;
	int  quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic track_result_t track_frame(input frame_t f);
		track_result_t r;
		int s;
		int d;
		longint t;
		r = '0;
		r.slot    = f.slot;
		r.angle   = f.angle;
		r.speed   = f.speed;
		r.current = SCALED_W'(32'(f.current) * 5);
		r.temp    = f.temp;
		if (f.slot < NUM_SLOTS) begin
			s = int'(f.slot);
			if (frame_cnt_slot[s] <= calib_setting) begin
				r.cal = 1'b1;
				offset_slot[s] = f.angle;
			end else begin
				d = int'(f.angle) - int'(prev_angle_slot[s]);
				if (d > HALF_TURN)
					turns_slot[s] = turns_slot[s] - 16'sd1;
				else if (d < -HALF_TURN)
					turns_slot[s] = turns_slot[s] + 16'sd1;
			end
			if (frame_cnt_slot[s] != CNT_MAX)
				frame_cnt_slot[s] = frame_cnt_slot[s] + 1'b1;
			prev_angle_slot[s] = f.angle;
			r.turns = turns_slot[s];
			t = longint'(turns_slot[s]) * TURN_COUNTS + longint'(f.angle)
				- longint'(offset_slot[s]);
			r.total = TOTAL_W'(t);
		end
		return r;
	endfunction

	function automatic int draw_gap(input bit steady);
		if (steady)
			return 0;
		return int'($urandom_range(0, 19));
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Result checker: each transfer against the oldest expectation
	always @(posedge clk) begin
		track_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no frame outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("slot_out", result_ch.slot_out, want.slot);
				check_field("calibrating", result_ch.calibrating, want.cal);
				check_field("angle_out", result_ch.angle_out, want.angle);
				check_field("speed_out", result_ch.speed_out, want.speed);
				check_field("current_scaled", result_ch.current_scaled, want.current);
				check_field("temperature_out", result_ch.temperature_out, want.temp);
				check_field("turn_count", result_ch.turn_count, want.turns);
				check_field("accum_angle", result_ch.accum_angle, want.total);
			end
		end
	end

	// Result receiver: random wait per transfer, plus an optional long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (result_ch.valid && result_ch.ready)
					recv_wait = draw_gap(recv_steady);
				else if (recv_wait > 0)
					recv_wait--;
				result_ch.ready <= (recv_wait == 0);
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one frame after a random gap; returns right after its transfer
	task automatic send_frame(input logic [SLOT_W-1:0] slot,
		input logic [ANGLE_W-1:0] angle, input logic signed [SPEED_W-1:0] speed,
		input logic [CURRENT_W-1:0] current, input logic [TEMP_W-1:0] temp);
		frame_t f;
		int gap;
		f = '{slot, angle, speed, current, temp};
		gap = draw_gap(send_steady);
		if (gap > 0) begin
			if (offering)
				frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid            <= 1'b1;
		frame_ch.motor_slot       <= f.slot;
		frame_ch.encoder_angle    <= f.angle;
		frame_ch.speed_word       <= f.speed;
		frame_ch.current_word     <= f.current;
		frame_ch.temperature_byte <= f.temp;
		offering = 1;
		do @(posedge clk); while (!frame_ch.ready);
		pending_results.push_back(track_frame(f));
	endtask

	task automatic park_frame();
		if (offering)
			frame_ch.valid <= 1'b0;
		offering = 0;
	endtask

	task automatic wait_idle();
		park_frame();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_calib(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		calib_setting = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reset value of the register: first frames of a slot calibrate
	task automatic test_reset_calibration();
		send_frame(4'd9, 13'd8191, 16'sh7FFF, 16'hFFFF, 8'hFF);
		send_frame(4'd9, 13'd0, -16'sh8000, 16'h0000, 8'h00);
		send_frame(4'd9, 13'd4000, 16'sd0, 16'h1234, 8'h5A);
	endtask

	// Turn counting around the half-turn threshold, both directions
	task automatic test_turn_steps();
		write_calib(6'd0);
		send_frame(4'd1, 13'd100, 16'sd100, 16'd10, 8'd30);
		send_frame(4'd1, 13'd8000, 16'sd100, 16'd10, 8'd30);
		send_frame(4'd1, 13'd10, 16'sd100, 16'd10, 8'd30);
		send_frame(4'd1, 13'd4106, -16'sd5, 16'd10, 8'd30);
		send_frame(4'd1, 13'd0, -16'sd5, 16'd10, 8'd30);
		send_frame(4'd1, 13'd4097, -16'sd5, 16'd10, 8'd30);
		send_frame(4'd1, 13'd1, -16'sd5, 16'd10, 8'd30);
	endtask

	// Slots beyond the last motor: pass-through only
	task automatic test_slot_out_of_range();
		send_frame(4'd10, 13'd8191, -16'sh8000, 16'hFFFF, 8'hFF);
		send_frame(4'd15, 13'd0, 16'sh7FFF, 16'h0000, 8'h00);
		send_frame(4'd12, 13'd4096, 16'sd1, 16'hAAAA, 8'h55);
	endtask

	// Run one slot forwards back to back, one turn every other frame
	task automatic test_turn_run();
		logic [ANGLE_W-1:0] a;
		int i;
		a = '0;
		send_steady = 1;
		recv_steady = 1;
		for (i = 0; i < 64; i++) begin
			send_frame(4'd2, a, SPEED_W'($urandom), CURRENT_W'($urandom), TEMP_W'($urandom));
			a = a + 13'd4095;
		end
		send_steady = 0;
		recv_steady = 0;
	endtask

	// Hold the receiver off while frames keep coming, so the input stalls
	task automatic test_backpressure();
		int i;
		wait_idle();
		hold_req = LONG_HOLD;
		send_steady = 1;
		for (i = 0; i < 30; i++)
			send_frame(SLOT_W'($urandom_range(0, 9)), ANGLE_W'($urandom),
				SPEED_W'($urandom), CURRENT_W'($urandom), TEMP_W'($urandom));
		send_steady = 0;
	endtask

	// Random phases over several register settings; mostly smooth rotation
	task automatic test_random(input int items_per_phase);
		logic [CNT_W-1:0] settings [6];
		logic [SLOT_W-1:0] slot;
		logic [ANGLE_W-1:0] angle;
		int p;
		int i;
		int roll;
		int step;
		settings = '{6'd62, 6'd63, 6'd0, 6'd31, CNT_W'($urandom_range(0, 62)), 6'd50};
		for (p = 0; p < 6; p++) begin
			write_calib(settings[p]);
			for (i = 0; i < items_per_phase; i++) begin
				if (i % 60 == 0) begin
					roll = int'($urandom_range(0, 9));
					send_steady = (roll == 0 || roll == 1);
					recv_steady = (roll == 1 || roll == 2);
				end
				roll = int'($urandom_range(0, 99));
				if (roll < 8) begin
					slot  = SLOT_W'($urandom_range(10, 15));
					angle = ANGLE_W'($urandom);
				end else begin
					slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
					if (roll < 20) begin
						angle = ANGLE_W'($urandom);
					end else begin
						if (roll < 30)
							step = int'($urandom_range(4090, 4102));
						else
							step = int'($urandom_range(0, 600));
						if ($urandom_range(0, 1))
							step = -step;
						angle = ANGLE_W'(int'(angle_track[slot]) + step);
					end
					angle_track[slot] = angle;
				end
				send_frame(slot, angle, SPEED_W'($urandom), CURRENT_W'($urandom),
					TEMP_W'($urandom));
			end
		end
		send_steady = 0;
		recv_steady = 0;
	endtask

	initial begin
		arst_n                    <= 1'b0;
		cfg_we                    <= 1'b0;
		cfg_wdata                 <= '0;
		frame_ch.valid            <= 1'b0;
		frame_ch.motor_slot       <= '0;
		frame_ch.encoder_angle    <= '0;
		frame_ch.speed_word       <= '0;
		frame_ch.current_word     <= '0;
		frame_ch.temperature_byte <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_turn_steps();
		test_slot_out_of_range();
		test_backpressure();
		test_random(240);
		test_turn_run();

		wait_idle();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
